// ----- rtl/core/lfcp_pkg.sv -----
`timescale 1ns / 1ps
package lfcp_pkg;
	localparam int unsigned SLOTS      = 16;
	localparam int unsigned FRAME_BITS = 20;

	typedef enum logic [1:0] {
		CMD_REQ   = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_INVAL = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_PREFETCH = 2'd0,
		KIND_HIT      = 2'd1,
		KIND_MISS     = 2'd2,
		KIND_OOR      = 2'd3
	} kind_t;

	localparam int unsigned REG_FRAME_COUNT = 0;
	localparam int unsigned REG_LOOP_FIRST  = 1;
	localparam int unsigned REG_LOOP_LAST   = 2;
	localparam int unsigned REG_CAPACITY    = 3;
	localparam int unsigned REG_LOOKAHEAD   = 4;

	localparam int unsigned FC_W   = 21;
	localparam int unsigned LOOP_W = 20;
	localparam int unsigned CAP_W  = 5;
	localparam int unsigned LA_W   = 4;
	localparam int unsigned GEN_W  = 8;
	localparam int unsigned OSLOT_W = 4;
	localparam int unsigned OFRAME_W = 20;

	typedef struct packed {
		logic [FC_W-1:0]   frame_count;
		logic [LOOP_W-1:0] loop_first;
		logic [LOOP_W-1:0] loop_last;
		logic [CAP_W-1:0]  capacity;
		logic [LA_W-1:0]   lookahead;
	} cfg_t;
endpackage

// ----- rtl/core/lfcp_if.sv -----
`timescale 1ns / 1ps
interface lfcp_in_if #(parameter int FRAME_BITS = 20);
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [FRAME_BITS-1:0] frame_id;
	logic                  load_ok;
	logic                  demand_load;
	logic [7:0]            load_generation;
	modport source (output valid, command, frame_id, load_ok, demand_load,
		load_generation, input ready);
	modport sink (input valid, command, frame_id, load_ok, demand_load,
		load_generation, output ready);
endinterface

interface lfcp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [19:0] out_frame;
	logic [3:0]  out_slot;
	logic [7:0]  out_generation;
	logic        last;
	modport source (output valid, kind, out_frame, out_slot, out_generation, last,
		input ready);
	modport sink (input valid, kind, out_frame, out_slot, out_generation, last,
		output ready);
endinterface

// ----- rtl/core/lfcp_divu.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module lfcp_divu import lfcp_pkg::*; #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  num_q;
	logic [W-1:0]  den_q;
	logic [W:0]    acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	assign trial = {acc_q[W-1:0], num_q[W-1]} - {1'b0, den_q};
	assign rem = acc_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			acc_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (!trial[W])
				acc_q <= {1'b0, trial[W-1:0]};
			else
				acc_q <= {acc_q[W-1:0], num_q[W-1]};
		end
	end
endmodule

// ----- rtl/core/lfcp_slot_mem.sv -----
`timescale 1ns / 1ps
// Slot store: tags in a synchronous memory, valid bits in flops.
module lfcp_slot_mem import lfcp_pkg::*; #(
	parameter int SLOTS = 16,
	parameter int FRAME_BITS = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic [FRAME_BITS-1:0]    rd_tag,
	output logic                     rd_valid,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  logic [FRAME_BITS-1:0]    wr_tag,
	input  logic                     clear
);
	logic [FRAME_BITS-1:0] tag_mem [SLOTS];
	logic [SLOTS-1:0]      valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			tag_mem[wr_addr] <= wr_tag;
		if (rd_en)
			rd_tag <= tag_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (rd_en)
				rd_valid <= valid_q[rd_addr];
			if (clear)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
		end
	end
endmodule

// ----- rtl/core/looped_frame_cache_prefetcher.sv -----
`timescale 1ns / 1ps
// Direct-mapped frame cache with looped sequential prefetch. An invalidate or an
// unknown command is finished in the idle state. A load completion takes its slot
// from a bit-serial remainder unit, which hands the result over when done; then, for
// a valid load, the tag memory is written. A request outside the frame count answers
// with one beat. Any other request emits up to fifteen prefetch beats then one
// hit/miss beat; each candidate frame passes through remainder start, slot division,
// tag read, check and emit, and prefetching first needs a loop modulo. A result beat
// waits for ready. Configuration registers sit on an APB port at byte addresses 4*i
// and must only be written while the block is idle.
module looped_frame_cache_prefetcher import lfcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	lfcp_in_if.sink     in_ch,
	lfcp_out_if.source  out_ch
);
	localparam int SW = $clog2(SLOTS);
	localparam int DW = 22;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOPMOD, ST_CAND, ST_SLOTDIV, ST_READ, ST_CHECK, ST_EMIT,
		ST_LOADDIV, ST_LOADRD
	} state_t;

	cfg_t cfg_q;
	state_t st_q;
	logic [GEN_W-1:0] gen_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= FC_W'(1);
			cfg_q.loop_first <= '0;
			cfg_q.loop_last <= '1;
			cfg_q.capacity <= CAP_W'(16);
			cfg_q.lookahead <= LA_W'(8);
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				3'(REG_FRAME_COUNT): cfg_q.frame_count <= pwdata[FC_W-1:0];
				3'(REG_LOOP_FIRST):  cfg_q.loop_first <= pwdata[LOOP_W-1:0];
				3'(REG_LOOP_LAST):   cfg_q.loop_last <= pwdata[LOOP_W-1:0];
				3'(REG_CAPACITY):    cfg_q.capacity <= pwdata[CAP_W-1:0];
				3'(REG_LOOKAHEAD):   cfg_q.lookahead <= pwdata[LA_W-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[4:2])
			3'(REG_FRAME_COUNT): prdata = 32'(cfg_q.frame_count);
			3'(REG_LOOP_FIRST):  prdata = 32'(cfg_q.loop_first);
			3'(REG_LOOP_LAST):   prdata = 32'(cfg_q.loop_last);
			3'(REG_CAPACITY):    prdata = 32'(cfg_q.capacity);
			3'(REG_LOOKAHEAD):   prdata = 32'(cfg_q.lookahead);
			default:             prdata = '0;
		endcase
	end

	// Derived setup values, all combinational on stable configuration.
	logic [CAP_W-1:0] cap_eff;
	logic [LA_W-1:0]  ahead_eff;
	logic [DW-1:0]    end_c, range_c;
	logic             win_ok;
	always_comb begin
		if (cfg_q.capacity == '0) cap_eff = CAP_W'(1);
		else if (32'(cfg_q.capacity) > SLOTS) cap_eff = CAP_W'(SLOTS);
		else cap_eff = cfg_q.capacity;
		if (32'(cfg_q.lookahead) > 32'(cap_eff) - 1) ahead_eff = LA_W'(cap_eff - 1'b1);
		else ahead_eff = cfg_q.lookahead;
		end_c = DW'(cfg_q.loop_last);
		if (cfg_q.frame_count == '0) end_c = '0;
		else if (DW'(cfg_q.loop_last) > DW'(cfg_q.frame_count) - 1'b1)
			end_c = DW'(cfg_q.frame_count) - 1'b1;
		win_ok = cfg_q.frame_count != '0 && DW'(cfg_q.loop_first) <= end_c;
		range_c = end_c - DW'(cfg_q.loop_first) + 1'b1;
	end

	// Request registers.
	logic [FRAME_BITS-1:0] frame_q, cand_q;
	logic [DW-1:0]         pos_q;
	logic [LA_W-1:0]       off_q;
	logic                  final_q, below_q, load_q;
	logic [SW-1:0]         slot_q;

	// Shared remainder unit.
	logic          div_start, div_done;
	logic [DW-1:0] div_a, div_b, div_r;
	lfcp_divu #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .rem(div_r)
	);

	logic                  rd_en, rd_valid, wr_en, clr;
	logic [FRAME_BITS-1:0] rd_tag;
	lfcp_slot_mem #(.SLOTS(SLOTS), .FRAME_BITS(FRAME_BITS)) u_mem (
		.clk(clk), .arst_n(arst_n), .rd_en(rd_en), .rd_addr(slot_q), .rd_tag(rd_tag),
		.rd_valid(rd_valid), .wr_en(wr_en), .wr_addr(slot_q), .wr_tag(frame_q),
		.clear(clr)
	);

	logic [DW-1:0] frame_w;
	logic          in_fire, out_fire, hit;
	assign frame_w = DW'(in_ch.frame_id);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign in_ch.ready = st_q == ST_IDLE;
	assign hit = rd_valid && rd_tag == cand_q;
	assign out_ch.out_generation = gen_q;

	always_comb begin
		div_start = 1'b0;
		div_a = DW'(cand_q);
		div_b = DW'(cap_eff);
		if (st_q == ST_IDLE && in_fire) begin
			div_a = frame_w;
			div_start = in_ch.command == CMD_LOAD;
			if (in_ch.command == CMD_REQ) begin
				div_start = 1'b1;
				if (win_ok && ahead_eff != '0 && in_ch.frame_id < cfg_q.frame_count) begin
					div_b = range_c;
					div_a = frame_w >= DW'(cfg_q.loop_first) ?
						frame_w - DW'(cfg_q.loop_first) :
						DW'(cfg_q.loop_first) - frame_w;
				end
			end
		end else if (st_q == ST_CAND) begin
			div_start = 1'b1;
		end
	end

	assign rd_en = st_q == ST_READ || st_q == ST_LOADRD;
	assign wr_en = st_q == ST_LOADRD && load_q;
	assign clr = st_q == ST_IDLE && in_fire && in_ch.command == CMD_INVAL;

	logic [DW-1:0] nxt_pos;
	always_comb begin
		nxt_pos = pos_q + 1'b1;
		if (nxt_pos >= range_c) nxt_pos = nxt_pos - range_c;
	end

	// Window position of the requested frame, then of the first candidate.
	logic [DW-1:0] rel_c, first_pos;
	always_comb begin
		rel_c = (below_q && div_r != '0) ? range_c - div_r : div_r;
		first_pos = rel_c + 1'b1;
		if (first_pos >= range_c) first_pos = first_pos - range_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			gen_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (in_fire) begin
					frame_q <= in_ch.frame_id;
					cand_q <= in_ch.frame_id;
					below_q <= in_ch.frame_id < FRAME_BITS'(cfg_q.loop_first);
					off_q <= '0;
					load_q <= in_ch.load_ok && (in_ch.demand_load ||
						in_ch.load_generation == gen_q) &&
						DW'(in_ch.frame_id) < DW'(cfg_q.frame_count);
					case (in_ch.command)
						CMD_INVAL: gen_q <= gen_q + 1'b1;
						CMD_LOAD:  st_q <= ST_LOADDIV;
						CMD_REQ: begin
							if (DW'(in_ch.frame_id) >= DW'(cfg_q.frame_count)) begin
								out_ch.kind <= KIND_OOR;
								out_ch.out_frame <= OFRAME_W'(in_ch.frame_id);
								out_ch.out_slot <= '0;
								out_ch.last <= 1'b1;
								out_ch.valid <= 1'b1;
								st_q <= ST_EMIT;
							end else if (win_ok && ahead_eff != '0)
								st_q <= ST_LOOPMOD;
							else begin
								final_q <= 1'b1;
								st_q <= ST_SLOTDIV;
							end
						end
						default: ;
					endcase
				end
				ST_LOOPMOD: if (div_done) begin
					final_q <= 1'b0;
					st_q <= ST_CAND;
				end
				ST_CAND: st_q <= ST_SLOTDIV;
				ST_SLOTDIV: begin
					if (final_q && off_q == '0 && !div_done) begin
						cand_q <= frame_q;
					end
					if (div_done) begin
						slot_q <= SW'(div_r);
						st_q <= ST_READ;
					end
				end
				ST_READ: st_q <= ST_CHECK;
				ST_CHECK: begin
					out_ch.out_frame <= OFRAME_W'(cand_q);
					out_ch.out_slot <= OSLOT_W'(slot_q);
					out_ch.last <= final_q;
					if (final_q) begin
						out_ch.kind <= hit ? KIND_HIT : KIND_MISS;
						out_ch.valid <= 1'b1;
						st_q <= ST_EMIT;
					end else if (!hit) begin
						out_ch.kind <= KIND_PREFETCH;
						out_ch.valid <= 1'b1;
						st_q <= ST_EMIT;
					end else
						st_q <= ST_EMIT;
				end
				ST_EMIT: if (!out_ch.valid || out_fire) begin
					out_ch.valid <= 1'b0;
					if (out_ch.last && (out_ch.valid))
						st_q <= ST_IDLE;
					else if (out_ch.last)
						st_q <= ST_IDLE;
					else if (off_q + 1'b1 == ahead_eff || final_q) begin
						final_q <= 1'b1;
						cand_q <= frame_q;
						off_q <= '0;
						st_q <= ST_CAND;
					end else begin
						off_q <= off_q + 1'b1;
						st_q <= ST_CAND;
					end
				end
				ST_LOADDIV: if (div_done) begin
					slot_q <= SW'(div_r);
					st_q <= ST_LOADRD;
				end
				ST_LOADRD: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			// Candidate frame for the next prefetch beat.
			if (st_q == ST_LOOPMOD && div_done) begin
				pos_q <= first_pos;
				cand_q <= FRAME_BITS'(DW'(cfg_q.loop_first) + first_pos);
			end
			if (st_q == ST_EMIT && (!out_ch.valid || out_fire) && !out_ch.last &&
				!(off_q + 1'b1 == ahead_eff || final_q)) begin
				pos_q <= nxt_pos;
				cand_q <= FRAME_BITS'(DW'(cfg_q.loop_first) + nxt_pos);
			end
		end
	end

	// The output register must hold while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result beat dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("new item accepted with a result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !clr)
		else $error("fill and invalidate in the same cycle");
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import lfcp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned DRAIN_PAD   = 60;
	localparam int unsigned NUM_SLOTS   = 16;

	typedef struct {
		kind_t       kind;
		logic [19:0] frame;
		logic [3:0]  slot;
		logic [7:0]  gen;
		logic        last;
	} beat_t;

	typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

	typedef struct {
		row_op_t     op;
		cmd_t        cmd;
		logic [19:0] frame;
		logic        ok;
		logic        demand;
		logic [7:0]  lgen;
		logic        typed;
		logic [7:0]  exp_gen;
		int unsigned reg_idx;
		logic [31:0] reg_val;
	} stim_row_t;

	typedef struct {
		logic [19:0] frame;
		logic [7:0]  gen;
		logic        demand;
	} load_ticket_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lfcp_in_if  req_ch();
	lfcp_out_if rsp_ch();

	looped_frame_cache_prefetcher u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (req_ch.sink),
		.out_ch  (rsp_ch.source)
	);

	// Shadow of the cache and its registers.
	logic [20:0] sh_frame_count;
	logic [19:0] sh_loop_first;
	logic [19:0] sh_loop_last;
	logic [4:0]  sh_capacity;
	logic [3:0]  sh_lookahead;
	logic [19:0] sh_tag [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] sh_valid;
	logic [7:0]  sh_gen;

	beat_t        beats_due[$];
	load_ticket_t load_pool[$];
	stim_row_t    dir_rows[$];
	int unsigned  mismatches;
	int unsigned  cycles;
	bit           calm;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic void push_beat(kind_t k, logic [19:0] f, logic [3:0] s, logic l);
		beat_t b;
		b.kind  = k;
		b.frame = f;
		b.slot  = s;
		b.gen   = sh_gen;
		b.last  = l;
		beats_due.push_back(b);
		if (k == KIND_PREFETCH || k == KIND_MISS) begin
			load_pool.push_back('{f, sh_gen, k == KIND_MISS});
			if (load_pool.size() > 32) void'(load_pool.pop_front());
		end
	endfunction

	// Advances the shadow cache by one accepted beat and queues what it causes.
	function automatic void cache_step(cmd_t c, logic [19:0] f, logic ok, logic dem,
		logic [7:0] lg);
		longint unsigned cap, fc, endf, ahead, range, rel, cand, s, off;
		fc  = sh_frame_count;
		cap = (sh_capacity == 0) ? 1 : (sh_capacity > NUM_SLOTS) ? NUM_SLOTS : sh_capacity;
		case (c)
			CMD_LOAD: begin
				if (ok && f < fc && (dem || lg == sh_gen)) begin
					s = f % cap;
					sh_tag[s]   = f;
					sh_valid[s] = 1'b1;
				end
			end
			CMD_INVAL: begin
				sh_valid = '0;
				sh_gen   = sh_gen + 8'd1;
			end
			CMD_REQ: begin
				if (f >= fc) begin
					push_beat(KIND_OOR, f, 4'd0, 1'b1);
				end else begin
					endf = sh_loop_last;
					if (endf > fc - 1) endf = fc - 1;
					ahead = sh_lookahead;
					if (ahead > cap - 1) ahead = cap - 1;
					if (sh_loop_first <= endf) begin
						range = endf - sh_loop_first + 1;
						// True modulo, also for frames below the window start.
						if (f >= sh_loop_first)
							rel = (f - sh_loop_first) % range;
						else
							rel = (range - ((sh_loop_first - f) % range)) % range;
						for (off = 1; off <= ahead; off++) begin
							cand = sh_loop_first + (rel + off) % range;
							s = cand % cap;
							if (!(sh_valid[s] && sh_tag[s] == cand))
								push_beat(KIND_PREFETCH, cand, s, 1'b0);
						end
					end
					s = f % cap;
					push_beat((sh_valid[s] && sh_tag[s] == f) ? KIND_HIT : KIND_MISS, f, s,
						1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		beat_t exp_b;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (beats_due.size() == 0) begin
				report($sformatf("unexpected beat kind %0d frame %0d", rsp_ch.kind,
					rsp_ch.out_frame));
			end else begin
				exp_b = beats_due.pop_front();
				if (rsp_ch.kind !== exp_b.kind)
					report($sformatf("kind %0d, want %0d (frame %0d)", rsp_ch.kind,
						exp_b.kind, exp_b.frame));
				if (rsp_ch.out_frame !== exp_b.frame)
					report($sformatf("frame %0d, want %0d", rsp_ch.out_frame, exp_b.frame));
				if (rsp_ch.out_slot !== exp_b.slot)
					report($sformatf("slot %0d, want %0d (frame %0d)", rsp_ch.out_slot,
						exp_b.slot, exp_b.frame));
				if (rsp_ch.out_generation !== exp_b.gen)
					report($sformatf("generation %0d, want %0d", rsp_ch.out_generation,
						exp_b.gen));
				if (rsp_ch.last !== exp_b.last)
					report($sformatf("last %0b, want %0b (frame %0d)", rsp_ch.last,
						exp_b.last, exp_b.frame));
			end
		end
	end

	// Receiver back-pressure: mostly short stalls, a few long ones.
	initial begin
		int unsigned r;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (calm || r < 60) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40))
					@(posedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic wait_idle();
		while (beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input int unsigned idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= 5'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FRAME_COUNT: sh_frame_count = val[FC_W-1:0];
			REG_LOOP_FIRST:  sh_loop_first  = val[LOOP_W-1:0];
			REG_LOOP_LAST:   sh_loop_last   = val[LOOP_W-1:0];
			REG_CAPACITY:    sh_capacity    = val[CAP_W-1:0];
			REG_LOOKAHEAD:   sh_lookahead   = val[LA_W-1:0];
			default: ;
		endcase
	endtask

	// Sends one beat; returns at the edge that accepted it, with valid still high.
	task automatic send_beat(input cmd_t c, input logic [19:0] f, input logic ok,
		input logic dem, input logic [7:0] lg, input bit typed, input logic [7:0] tgen);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!calm && r >= 70) begin
			req_ch.valid <= 1'b0;
			repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40))
				@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.command         <= c;
		req_ch.frame_id        <= f;
		req_ch.load_ok         <= ok;
		req_ch.demand_load     <= dem;
		req_ch.load_generation <= lg;
		do @(posedge clk); while (!req_ch.ready);
		if (typed) begin
			// Out-of-range answer is read straight off the request.
			beats_due.push_back('{KIND_OOR, f, 4'd0, tgen, 1'b1});
		end else begin
			cache_step(c, f, ok, dem, lg);
		end
	endtask

	task automatic stop_sending();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_row(input int unsigned idx, input logic [31:0] val);
		dir_rows.push_back('{ROW_CFG, CMD_NONE, 20'd0, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0, idx, val});
	endtask

	task automatic item_row(input cmd_t c, input logic [19:0] f, input logic ok,
		input logic dem, input logic [7:0] lg, input bit typed, input logic [7:0] tgen);
		dir_rows.push_back('{ROW_ITEM, c, f, ok, dem, lg, typed, tgen, 0, 32'd0});
	endtask

	initial begin
		logic [31:0] fc, first, lastf;
		logic [19:0] f;
		int unsigned r, pick;
		load_ticket_t t;
		bit in_cfg;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_ch.valid = 1'b0;
		req_ch.command         = CMD_NONE;
		req_ch.frame_id        = '0;
		req_ch.load_ok         = 1'b0;
		req_ch.demand_load     = 1'b0;
		req_ch.load_generation = '0;
		cycles     = 0;
		mismatches = 0;
		calm       = 1'b0;
		sh_frame_count = 21'd1;
		sh_loop_first  = 20'd0;
		sh_loop_last   = 20'hFFFFF;
		sh_capacity    = 5'd16;
		sh_lookahead   = 4'd8;
		sh_valid       = '0;
		sh_gen         = 8'd0;
		for (int i = 0; i < NUM_SLOTS; i++) sh_tag[i] = '0;

		// Reset registers: one frame, so anything above frame zero is out of range.
		item_row(CMD_REQ, 20'd1, 0, 0, 0, 1, 8'd0);
		item_row(CMD_REQ, 20'hFFFFF, 0, 0, 0, 1, 8'd0);
		item_row(CMD_REQ, 20'd0, 0, 0, 0, 0, 0);
		item_row(CMD_LOAD, 20'd0, 1, 1, 8'd0, 0, 0);
		item_row(CMD_REQ, 20'd0, 0, 0, 0, 0, 0);
		item_row(CMD_INVAL, 20'd0, 0, 0, 0, 0, 0);
		item_row(CMD_LOAD, 20'd0, 1, 0, 8'd0, 0, 0);
		item_row(CMD_NONE, 20'd0, 1, 1, 8'hFF, 0, 0);
		item_row(CMD_REQ, 20'd0, 0, 0, 0, 0, 0);
		item_row(CMD_LOAD, 20'd0, 1, 0, 8'd1, 0, 0);
		item_row(CMD_REQ, 20'd7, 0, 0, 0, 1, 8'd1);
		// Full frame range, window 100..115, deepest lookahead.
		cfg_row(REG_FRAME_COUNT, 32'd1048576);
		cfg_row(REG_LOOP_FIRST, 32'd100);
		cfg_row(REG_LOOP_LAST, 32'd115);
		cfg_row(REG_LOOKAHEAD, 32'd15);
		item_row(CMD_REQ, 20'd50, 0, 0, 0, 0, 0);
		item_row(CMD_LOAD, 20'd101, 0, 0, 8'd1, 0, 0);
		item_row(CMD_LOAD, 20'd102, 1, 0, 8'd1, 0, 0);
		item_row(CMD_REQ, 20'd115, 0, 0, 0, 0, 0);
		item_row(CMD_REQ, 20'hFFFFF, 0, 0, 0, 0, 0);
		// Empty window and capacity zero.
		cfg_row(REG_LOOP_FIRST, 32'hFFFFF);
		cfg_row(REG_LOOP_LAST, 32'd0);
		cfg_row(REG_CAPACITY, 32'd0);
		item_row(CMD_REQ, 20'd3, 0, 0, 0, 0, 0);
		// Capacity above the slot count, then no frames at all.
		cfg_row(REG_CAPACITY, 32'd31);
		cfg_row(REG_LOOP_FIRST, 32'd0);
		cfg_row(REG_LOOP_LAST, 32'd40);
		item_row(CMD_REQ, 20'd38, 0, 0, 0, 0, 0);
		cfg_row(REG_FRAME_COUNT, 32'd0);
		item_row(CMD_REQ, 20'd0, 0, 0, 0, 1, 8'd1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		in_cfg = 1'b0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_CFG) begin
				if (!in_cfg) begin
					stop_sending();
					wait_idle();
					in_cfg = 1'b1;
				end
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				in_cfg = 1'b0;
				send_beat(dir_rows[i].cmd, dir_rows[i].frame, dir_rows[i].ok,
					dir_rows[i].demand, dir_rows[i].lgen, dir_rows[i].typed,
					dir_rows[i].exp_gen);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			stop_sending();
			wait_idle();
			calm = (ph == 2);
			r = $urandom_range(0, 9);
			fc = (ph == 0) ? 32'd1048576 : (r == 0) ? 32'd0 : (r == 1) ? 32'h1FFFFF :
				$urandom_range(1, 200);
			first = (fc > 1000) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(0, fc + 4);
			lastf = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20'hFFFFF) :
				first + $urandom_range(0, 40);
			write_reg(REG_FRAME_COUNT, fc);
			write_reg(REG_LOOP_FIRST, first);
			write_reg(REG_LOOP_LAST, lastf);
			write_reg(REG_CAPACITY, (ph == 1) ? 32'd16 : $urandom_range(0, 31));
			write_reg(REG_LOOKAHEAD, (ph == 1) ? 32'd15 : $urandom_range(0, 15));
			for (int n = 0; n < 40; n++) begin
				if (ph == 3 && n == 20) begin
					stop_sending();
					while (beats_due.size() != 0) @(posedge clk);
				end
				r = $urandom_range(0, 99);
				if (r < 55) begin
					if ($urandom_range(0, 19) == 0 || sh_frame_count > 1000)
						f = (sh_frame_count > 1000 && $urandom_range(0, 1)) ?
							20'(first + $urandom_range(0, 60)) : 20'($urandom);
					else
						f = 20'($urandom_range(0, sh_frame_count + 2));
					send_beat(CMD_REQ, f, 0, 0, 8'($urandom), 0, 0);
				end else if (r < 85 && load_pool.size() != 0) begin
					pick = $urandom_range(0, load_pool.size() - 1);
					t = load_pool[pick];
					load_pool.delete(pick);
					send_beat(CMD_LOAD, t.frame, $urandom_range(0, 9) != 0, t.demand, t.gen,
						0, 0);
				end else if (r < 90) begin
					send_beat(CMD_INVAL, 20'($urandom), 1'($urandom), 1'($urandom),
						8'($urandom), 0, 0);
				end else if (r < 97) begin
					send_beat(CMD_LOAD, 20'($urandom), 1'($urandom), 1'($urandom),
						8'($urandom), 0, 0);
				end else begin
					send_beat(CMD_NONE, 20'($urandom), 1'($urandom), 1'($urandom),
						8'($urandom), 0, 0);
				end
			end
		end

		stop_sending();
		wait_idle();
		if (mismatches == 0 && beats_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
